FILE: rtl/mas_pkg.sv
package mas_pkg;

  localparam int TIMER_BITS_DEF = 16;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BEAN_TEMP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AIR_TEMP = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_BAND = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RISE_RATE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_BAND = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISMATCH_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_AGITATOR_WATCH = 3'd6;

  localparam int ALM_OVERTEMP = 0;
  localparam int ALM_SENSOR = 1;
  localparam int ALM_RISE = 2;
  localparam int ALM_EMERGENCY = 3;
  localparam int ALM_MOTORS = 4;
  localparam int ALM_AGITATOR = 5;
  localparam int ALM_COOLER = 6;
  localparam int ALM_BITS = 7;

  typedef struct packed {
    logic [13:0] max_bean_temp;
    logic [13:0] max_air_temp;
    logic [9:0]  temp_band;
    logic [13:0] max_rise_rate;
    logic [9:0]  rise_band;
    logic [15:0] mismatch_timeout_ms;
    logic        agitator_watch_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    max_bean_temp: 14'd2500,
    max_air_temp: 14'd3500,
    temp_band: 10'd100,
    max_rise_rate: 14'd300,
    rise_band: 10'd10,
    mismatch_timeout_ms: 16'd5000,
    agitator_watch_enable: 1'b1
  };

  typedef struct packed {
    logic signed [14:0] bean_temp;
    logic signed [14:0] air_temp;
    logic signed [14:0] rise_rate;
    logic               emergency;
    logic               run_cmd;
    logic               drum_ok;
    logic               exhaust_ok;
    logic               agitate_cmd;
    logic               agitator_ok;
    logic               cool_cmd;
    logic               cooler_ok;
    logic [9:0]         elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [ALM_BITS-1:0] alarm_flags;
    logic                temp_ok;
    logic                burner_minimum;
    logic                run_lamp;
    logic                agitate_lamp;
    logic                cool_lamp;
    logic                discharge_lamp;
  } result_t;

endpackage

FILE: rtl/mas_channels.sv
interface mas_tick_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] bean_temp;
  logic signed [14:0] air_temp;
  logic signed [14:0] rise_rate;
  logic               emergency;
  logic               run_cmd;
  logic               drum_ok;
  logic               exhaust_ok;
  logic               agitate_cmd;
  logic               agitator_ok;
  logic               cool_cmd;
  logic               cooler_ok;
  logic [9:0]         elapsed_ms;

  modport source (
    output valid, bean_temp, air_temp, rise_rate, emergency, run_cmd, drum_ok,
    output exhaust_ok, agitate_cmd, agitator_ok, cool_cmd, cooler_ok, elapsed_ms,
    input ready
  );
  modport sink (
    input valid, bean_temp, air_temp, rise_rate, emergency, run_cmd, drum_ok,
    input exhaust_ok, agitate_cmd, agitator_ok, cool_cmd, cooler_ok, elapsed_ms,
    output ready
  );
endinterface

interface mas_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] alarm_flags;
  logic       temp_ok;
  logic       burner_minimum;
  logic       run_lamp;
  logic       agitate_lamp;
  logic       cool_lamp;
  logic       discharge_lamp;

  modport source (
    output valid, alarm_flags, temp_ok, burner_minimum, run_lamp, agitate_lamp,
    output cool_lamp, discharge_lamp,
    input ready
  );
  modport sink (
    input valid, alarm_flags, temp_ok, burner_minimum, run_lamp, agitate_lamp,
    input cool_lamp, discharge_lamp,
    output ready
  );
endinterface

interface mas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/mas_cfg_regs.sv
module mas_cfg_regs
  import mas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CFG_IDX_BITS-1:0]  wr_index,
  input  logic [CFG_DATA_BITS-1:0] wr_data,
  output cfg_t                     cfg
);

  cfg_t regs;
  cfg_t regs_next;

  always_comb begin
    regs_next = regs;
    if (wr_en) begin
      unique case (wr_index)
        REG_MAX_BEAN_TEMP:    regs_next.max_bean_temp = wr_data[13:0];
        REG_MAX_AIR_TEMP:     regs_next.max_air_temp = wr_data[13:0];
        REG_TEMP_BAND:        regs_next.temp_band = wr_data[9:0];
        REG_MAX_RISE_RATE:    regs_next.max_rise_rate = wr_data[13:0];
        REG_RISE_BAND:        regs_next.rise_band = wr_data[9:0];
        REG_MISMATCH_TIMEOUT: regs_next.mismatch_timeout_ms = wr_data;
        REG_AGITATOR_WATCH:   regs_next.agitator_watch_enable = wr_data[0];
        default:              regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

FILE: rtl/mas_mismatch.sv
module mas_mismatch
  import mas_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        cmd,
  input  logic        ok,
  input  logic        may_set,
  input  logic [9:0]  elapsed_ms,
  input  logic [15:0] timeout_ms,
  output logic        alarm_next
);

  localparam int SW = (TIMER_BITS > 10 ? TIMER_BITS : 10) + 1;
  localparam int CW = TIMER_BITS > 16 ? TIMER_BITS : 16;

  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic                  running;
  logic                  alarm;
  logic [SW-1:0]         sum;
  logic                  due;

  assign sum = SW'(timer) + SW'(elapsed_ms);

  always_comb begin
    if (!cmd) begin
      timer_next = '0;
    end else if (!running) begin
      timer_next = '0;
    end else if (sum > SW'({TIMER_BITS{1'b1}})) begin
      timer_next = {TIMER_BITS{1'b1}};
    end else begin
      timer_next = sum[TIMER_BITS-1:0];
    end
  end

  assign due = CW'(timer_next) >= CW'(timeout_ms);

  always_comb begin
    alarm_next = alarm;
    if (cmd && !ok && may_set && due) begin
      alarm_next = 1'b1;
    end
    if (!cmd || ok) begin
      alarm_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
      running <= 1'b0;
      alarm <= 1'b0;
    end else if (en) begin
      timer <= timer_next;
      running <= cmd;
      alarm <= alarm_next;
    end
  end

endmodule

FILE: rtl/mas_eval.sv
module mas_eval
  import mas_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t res
);

  logic signed [15:0] bt;
  logic signed [15:0] at;
  logic signed [15:0] rate;
  logic signed [15:0] maxb;
  logic signed [15:0] maxa;
  logic signed [15:0] maxr;
  logic signed [15:0] maxb_low;
  logic signed [15:0] maxa_low;
  logic signed [15:0] maxr_low;

  logic overtemp;
  logic overtemp_next;
  logic temp_ok;
  logic temp_ok_next;
  logic rise;
  logic rise_next;
  logic discharge;
  logic discharge_next;
  logic sensor;
  logic both_run;
  logic motors_alarm;
  logic agitator_alarm;
  logic cooler_alarm;

  assign bt = {item.bean_temp[14], item.bean_temp};
  assign at = {item.air_temp[14], item.air_temp};
  assign rate = {item.rise_rate[14], item.rise_rate};
  assign maxb = {2'b00, cfg.max_bean_temp};
  assign maxa = {2'b00, cfg.max_air_temp};
  assign maxr = {2'b00, cfg.max_rise_rate};
  assign maxb_low = maxb - {6'b0, cfg.temp_band};
  assign maxa_low = maxa - {6'b0, cfg.temp_band};
  assign maxr_low = maxr - {6'b0, cfg.rise_band};

  assign sensor = (at <= 16'sd0) || (bt <= 16'sd0);
  assign both_run = item.drum_ok && item.exhaust_ok;

  always_comb begin
    overtemp_next = overtemp;
    temp_ok_next = temp_ok;
    if (bt > maxb || at > maxa) begin
      overtemp_next = 1'b1;
      temp_ok_next = 1'b0;
    end else if (bt < maxb_low && at < maxa_low) begin
      overtemp_next = 1'b0;
      temp_ok_next = 1'b1;
    end
    if (sensor) begin
      temp_ok_next = 1'b0;
    end
  end

  always_comb begin
    rise_next = rise;
    if (rate > maxr) begin
      rise_next = 1'b1;
    end else if (rate < maxr_low) begin
      rise_next = 1'b0;
    end
  end

  always_comb begin
    discharge_next = discharge;
    if (item.cooler_ok && item.agitator_ok) begin
      discharge_next = 1'b1;
    end else if (!item.cooler_ok && !item.agitator_ok) begin
      discharge_next = 1'b0;
    end
  end

  mas_mismatch #(.TIMER_BITS(TIMER_BITS)) u_motors (
    .clk(clk), .rst(rst), .en(en),
    .cmd(item.run_cmd), .ok(both_run), .may_set(1'b1),
    .elapsed_ms(item.elapsed_ms), .timeout_ms(cfg.mismatch_timeout_ms),
    .alarm_next(motors_alarm)
  );

  mas_mismatch #(.TIMER_BITS(TIMER_BITS)) u_agitator (
    .clk(clk), .rst(rst), .en(en),
    .cmd(item.agitate_cmd), .ok(item.agitator_ok), .may_set(cfg.agitator_watch_enable),
    .elapsed_ms(item.elapsed_ms), .timeout_ms(cfg.mismatch_timeout_ms),
    .alarm_next(agitator_alarm)
  );

  mas_mismatch #(.TIMER_BITS(TIMER_BITS)) u_cooler (
    .clk(clk), .rst(rst), .en(en),
    .cmd(item.cool_cmd), .ok(item.cooler_ok), .may_set(1'b1),
    .elapsed_ms(item.elapsed_ms), .timeout_ms(cfg.mismatch_timeout_ms),
    .alarm_next(cooler_alarm)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      overtemp <= 1'b0;
      temp_ok <= 1'b0;
      rise <= 1'b0;
      discharge <= 1'b0;
    end else if (en) begin
      overtemp <= overtemp_next;
      temp_ok <= temp_ok_next;
      rise <= rise_next;
      discharge <= discharge_next;
    end
  end

  always_comb begin
    res.alarm_flags[ALM_OVERTEMP] = overtemp_next;
    res.alarm_flags[ALM_SENSOR] = sensor;
    res.alarm_flags[ALM_RISE] = rise_next;
    res.alarm_flags[ALM_EMERGENCY] = item.emergency;
    res.alarm_flags[ALM_MOTORS] = motors_alarm;
    res.alarm_flags[ALM_AGITATOR] = agitator_alarm;
    res.alarm_flags[ALM_COOLER] = cooler_alarm;
    res.temp_ok = temp_ok_next;
    res.burner_minimum = rise_next;
    res.run_lamp = both_run;
    res.agitate_lamp = item.agitator_ok;
    res.cool_lamp = item.cooler_ok;
    res.discharge_lamp = discharge_next;
  end

endmodule

FILE: rtl/machine_alarm_supervisor_top.sv
// Path: a tick is captured in the input register, evaluated, and its result is
// captured in the result register, from which it is offered as the result transaction.
// Throughput: one tick per cycle while the result side is ready, set by the
// single evaluation stage between the input register and the result register.
// Reset: synchronous; clears both stage valids, alarm state, timers and the
// discharge flag, and loads the default limits. No clearing pass is needed.
module machine_alarm_supervisor_top
  import mas_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  mas_tick_if.sink    tick,
  mas_cfg_if.sink     cfg,
  mas_result_if.source result
);

  cfg_t    cfg_q;
  item_t   in_q;
  logic    in_valid;
  result_t eval_res;
  result_t out_q;
  logic    out_valid;
  logic    advance;

  assign cfg.ready = 1'b1;

  mas_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .wr_en(cfg.valid && cfg.ready),
    .wr_index(cfg.index),
    .wr_data(cfg.wdata),
    .cfg(cfg_q)
  );

  assign advance = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_q.bean_temp <= tick.bean_temp;
      in_q.air_temp <= tick.air_temp;
      in_q.rise_rate <= tick.rise_rate;
      in_q.emergency <= tick.emergency;
      in_q.run_cmd <= tick.run_cmd;
      in_q.drum_ok <= tick.drum_ok;
      in_q.exhaust_ok <= tick.exhaust_ok;
      in_q.agitate_cmd <= tick.agitate_cmd;
      in_q.agitator_ok <= tick.agitator_ok;
      in_q.cool_cmd <= tick.cool_cmd;
      in_q.cooler_ok <= tick.cooler_ok;
      in_q.elapsed_ms <= tick.elapsed_ms;
    end
  end

  mas_eval #(.TIMER_BITS(TIMER_BITS)) u_eval (
    .clk(clk),
    .rst(rst),
    .en(advance),
    .cfg(cfg_q),
    .item(in_q),
    .res(eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= eval_res;
    end
  end

  assign result.valid = out_valid;
  assign result.alarm_flags = out_q.alarm_flags;
  assign result.temp_ok = out_q.temp_ok;
  assign result.burner_minimum = out_q.burner_minimum;
  assign result.run_lamp = out_q.run_lamp;
  assign result.agitate_lamp = out_q.agitate_lamp;
  assign result.cool_lamp = out_q.cool_lamp;
  assign result.discharge_lamp = out_q.discharge_lamp;

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_q.burner_minimum == out_q.alarm_flags[ALM_RISE]))
    else $error("burner minimum differs from rise alarm");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_q.alarm_flags[ALM_SENSOR] || out_q.alarm_flags[ALM_OVERTEMP])
      |-> !out_q.temp_ok)
    else $error("temp_ok high with a temperature alarm");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.run_lamp |-> !out_q.alarm_flags[ALM_MOTORS])
    else $error("motor mismatch alarm while motors confirmed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(out_q))
    else $error("held result changed while stalled");

endmodule
